@@ rtl/box_circle_overlap_test_defines.svh @@
// Assertion macros shared by the overlap test RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef BOX_CIRCLE_OVERLAP_TEST_DEFINES_SVH
`define BOX_CIRCLE_OVERLAP_TEST_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define BCOT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define BCOT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bcot_pkg.sv @@
// Shared types and constants for the box/circle overlap test.
// No dependencies.
`default_nettype none

package bcot_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int SIZE_BITS      = 15;
  localparam int SUM_BITS       = SIZE_BITS + 1;
  localparam int SQ_BITS        = 2 * SUM_BITS;

  // pair class: box/box, circle/circle, circle/box (either order)
  typedef enum logic [1:0] {
    MODE_BB,
    MODE_CC,
    MODE_CB
  } mode_t;

  // control that travels down the pipe with each word
  typedef struct packed {
    logic  valid;
    mode_t mode;
    logic  bb_hit;
    logic  far;
  } stage_ctl_t;

endpackage

`default_nettype wire

@@ rtl/box_circle_overlap_test.sv @@
// Top level of the 2-D box/circle overlap test.
// Depends on bcot_pkg, bcot_front, bcot_square, bcot_decide.
//
// Usage:
//   Input word: two shapes (kind, center, size) on the in_ ports. A word is
//   taken at a rising clock edge where start is high and busy is low. busy
//   stays low: the pipeline takes one word every cycle.
//   Result word: out_overlap is shown for one cycle with out_strobe high,
//   once the word has passed the four register stages. The receiver cannot
//   hold results off, and nothing backs up. Throughput: 1 word per cycle.
//   The stages are distance/bound select, clamp and box compare, radius
//   reject with three 16x16 squarings, and the sum-of-squares compare.
//   Reset (rst_n low, synchronous) clears the valid bits of all stages, so
//   words in flight are dropped and out_strobe is low afterwards until new
//   words arrive. There is no state between words.
`default_nettype none

`include "box_circle_overlap_test_defines.svh"

module box_circle_overlap_test #(
  parameter int COORD_BITS = bcot_pkg::COORD_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  output logic                              busy,
  input  wire                               in_kind_a,
  input  wire  signed [COORD_BITS-1:0]      in_center_a_x,
  input  wire  signed [COORD_BITS-1:0]      in_center_a_y,
  input  wire         [bcot_pkg::SIZE_BITS-1:0] in_size_a_x,
  input  wire         [bcot_pkg::SIZE_BITS-1:0] in_size_a_y,
  input  wire                               in_kind_b,
  input  wire  signed [COORD_BITS-1:0]      in_center_b_x,
  input  wire  signed [COORD_BITS-1:0]      in_center_b_y,
  input  wire         [bcot_pkg::SIZE_BITS-1:0] in_size_b_x,
  input  wire         [bcot_pkg::SIZE_BITS-1:0] in_size_b_y,
  output logic                              out_strobe,
  output logic                              out_overlap
);
  import bcot_pkg::*;

  logic                accept;
  stage_ctl_t          ctl_front, ctl_sq;
  logic [COORD_BITS:0] ux, uy;
  logic [SUM_BITS-1:0] lim;
  logic [SQ_BITS-1:0]  sqx, sqy, sqr;

  // never stalls
  assign busy   = 1'b0;
  assign accept = start && !busy;

  bcot_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept_i     (accept),
    .kind_a_i     (in_kind_a),
    .center_a_x_i (in_center_a_x),
    .center_a_y_i (in_center_a_y),
    .size_a_x_i   (in_size_a_x),
    .size_a_y_i   (in_size_a_y),
    .kind_b_i     (in_kind_b),
    .center_b_x_i (in_center_b_x),
    .center_b_y_i (in_center_b_y),
    .size_b_x_i   (in_size_b_x),
    .size_b_y_i   (in_size_b_y),
    .ctl_o        (ctl_front),
    .ux_o         (ux),
    .uy_o         (uy),
    .lim_o        (lim)
  );

  bcot_square #(
    .COORD_BITS(COORD_BITS)
  ) u_square (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (ctl_front),
    .ux_i  (ux),
    .uy_i  (uy),
    .lim_i (lim),
    .ctl_o (ctl_sq),
    .sqx_o (sqx),
    .sqy_o (sqy),
    .sqr_o (sqr)
  );

  bcot_decide u_decide (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_i     (ctl_sq),
    .sqx_i     (sqx),
    .sqy_i     (sqy),
    .sqr_i     (sqr),
    .strobe_o  (out_strobe),
    .overlap_o (out_overlap)
  );

  // every accepted word gives a result, and no result comes without one
  `BCOT_ASSERT_NEXT(a_word_out, accept, ##3 out_strobe, "accepted word produced no result")
  `BCOT_ASSERT_NOW(a_no_phantom, out_strobe, $past(accept, 4), "result without an input word")

endmodule

`default_nettype wire

@@ rtl/bcot_front.sv @@
// First two pipeline stages: axis distances, bound selection, box test, clamp offset.
// Depends on bcot_pkg.
`default_nettype none

`include "box_circle_overlap_test_defines.svh"

module bcot_front #(
  parameter int COORD_BITS = bcot_pkg::COORD_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               accept_i,
  input  wire                               kind_a_i,
  input  wire  signed [COORD_BITS-1:0]      center_a_x_i,
  input  wire  signed [COORD_BITS-1:0]      center_a_y_i,
  input  wire         [bcot_pkg::SIZE_BITS-1:0] size_a_x_i,
  input  wire         [bcot_pkg::SIZE_BITS-1:0] size_a_y_i,
  input  wire                               kind_b_i,
  input  wire  signed [COORD_BITS-1:0]      center_b_x_i,
  input  wire  signed [COORD_BITS-1:0]      center_b_y_i,
  input  wire         [bcot_pkg::SIZE_BITS-1:0] size_b_x_i,
  input  wire         [bcot_pkg::SIZE_BITS-1:0] size_b_y_i,
  output bcot_pkg::stage_ctl_t              ctl_o,
  output logic        [COORD_BITS:0]        ux_o,
  output logic        [COORD_BITS:0]        uy_o,
  output logic        [bcot_pkg::SUM_BITS-1:0] lim_o
);
  import bcot_pkg::*;

  localparam int CW = COORD_BITS + 1;
  localparam int MW = (CW > SUM_BITS) ? CW : SUM_BITS;

  // ---- stage 1: doubled distance magnitudes and per-mode bounds ----
  logic [CW-1:0]        dx, dy, nx, ny;
  logic [CW-1:0]        adx_nxt, ady_nxt;
  logic [SUM_BITS-1:0]  sum_x, sum_y;
  logic [SUM_BITS-1:0]  lx_nxt, ly_nxt;
  logic [SIZE_BITS-1:0] hx_nxt, hy_nxt;
  mode_t                mode_nxt;

  logic                 s1_valid_r;
  mode_t                s1_mode_r;
  logic [CW-1:0]        adx_r, ady_r;
  logic [SUM_BITS-1:0]  lx_r, ly_r;
  logic [SIZE_BITS-1:0] hx_r, hy_r;

  always_comb begin
    dx = {center_a_x_i[COORD_BITS-1], center_a_x_i}
       - {center_b_x_i[COORD_BITS-1], center_b_x_i};
    dy = {center_a_y_i[COORD_BITS-1], center_a_y_i}
       - {center_b_y_i[COORD_BITS-1], center_b_y_i};
    nx = dx[CW-1] ? -dx : dx;
    ny = dy[CW-1] ? -dy : dy;
    // magnitude fits COORD_BITS; doubling is a shift
    adx_nxt = {nx[COORD_BITS-1:0], 1'b0};
    ady_nxt = {ny[COORD_BITS-1:0], 1'b0};
    sum_x = {1'b0, size_a_x_i} + {1'b0, size_b_x_i};
    sum_y = {1'b0, size_a_y_i} + {1'b0, size_b_y_i};
  end

  always_comb begin
    mode_nxt = MODE_BB;
    lx_nxt   = sum_x;
    ly_nxt   = sum_y;
    hx_nxt   = '0;
    hy_nxt   = '0;
    case ({kind_a_i, kind_b_i})
      2'b00: begin
        mode_nxt = MODE_BB;
      end
      2'b11: begin
        mode_nxt = MODE_CC;
        ly_nxt   = sum_x;
      end
      2'b10: begin
        // a is the circle, b the box
        mode_nxt = MODE_CB;
        lx_nxt   = {1'b0, size_a_x_i};
        ly_nxt   = {1'b0, size_a_x_i};
        hx_nxt   = size_b_x_i;
        hy_nxt   = size_b_y_i;
      end
      2'b01: begin
        // swapped: b is the circle
        mode_nxt = MODE_CB;
        lx_nxt   = {1'b0, size_b_x_i};
        ly_nxt   = {1'b0, size_b_x_i};
        hx_nxt   = size_a_x_i;
        hy_nxt   = size_a_y_i;
      end
      default: begin
        mode_nxt = MODE_BB;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept_i;
    end
    s1_mode_r <= mode_nxt;
    adx_r     <= adx_nxt;
    ady_r     <= ady_nxt;
    lx_r      <= lx_nxt;
    ly_r      <= ly_nxt;
    hx_r      <= hx_nxt;
    hy_r      <= hy_nxt;
  end

  // ---- stage 2: box test, offset past the box half-extents ----
  logic [MW-1:0] adx_w, ady_w, hx_w, hy_w, ex_w, ey_w;
  logic [CW-1:0] ux_nxt, uy_nxt;
  logic          bb_hit_nxt;
  stage_ctl_t    ctl_r;
  logic [CW-1:0] ux_r, uy_r;
  logic [SUM_BITS-1:0] lim_r;

  always_comb begin
    adx_w = MW'(adx_r);
    ady_w = MW'(ady_r);
    hx_w  = MW'(hx_r);
    hy_w  = MW'(hy_r);
    ex_w  = (adx_w > hx_w) ? (adx_w - hx_w) : '0;
    ey_w  = (ady_w > hy_w) ? (ady_w - hy_w) : '0;
    bb_hit_nxt = (adx_w <= MW'(lx_r)) && (ady_w <= MW'(ly_r));
    if (s1_mode_r == MODE_CB) begin
      ux_nxt = ex_w[CW-1:0];
      uy_nxt = ey_w[CW-1:0];
    end else begin
      ux_nxt = adx_r;
      uy_nxt = ady_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= s1_valid_r;
    end
    ctl_r.mode   <= s1_mode_r;
    ctl_r.bb_hit <= bb_hit_nxt;
    ctl_r.far    <= 1'b0;
    ux_r         <= ux_nxt;
    uy_r         <= uy_nxt;
    lim_r        <= lx_r;
  end

  assign ctl_o = ctl_r;
  assign ux_o  = ux_r;
  assign uy_o  = uy_r;
  assign lim_o = lim_r;

  // clamped offset never exceeds the raw distance
  `BCOT_ASSERT_NEXT(a_clamp_le_dist, s1_valid_r && (s1_mode_r == MODE_CB),
    (ux_r <= $past(adx_r)) && (uy_r <= $past(ady_r)), "clamped offset exceeds distance")

endmodule

`default_nettype wire

@@ rtl/bcot_square.sv @@
// Third pipeline stage: early rejection against the radius bound and squaring.
// Depends on bcot_pkg.
`default_nettype none

module bcot_square #(
  parameter int COORD_BITS = bcot_pkg::COORD_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  bcot_pkg::stage_ctl_t              ctl_i,
  input  wire  [COORD_BITS:0]               ux_i,
  input  wire  [COORD_BITS:0]               uy_i,
  input  wire  [bcot_pkg::SUM_BITS-1:0]     lim_i,
  output bcot_pkg::stage_ctl_t              ctl_o,
  output logic [bcot_pkg::SQ_BITS-1:0]      sqx_o,
  output logic [bcot_pkg::SQ_BITS-1:0]      sqy_o,
  output logic [bcot_pkg::SQ_BITS-1:0]      sqr_o
);
  import bcot_pkg::*;

  localparam int CW = COORD_BITS + 1;
  localparam int MW = (CW > SUM_BITS) ? CW : SUM_BITS;

  logic [MW-1:0]       ux_w, uy_w, lim_w;
  logic [SUM_BITS-1:0] opx, opy;
  logic                far_nxt;
  stage_ctl_t          ctl_r;
  logic [SQ_BITS-1:0]  sqx_r, sqy_r, sqr_r;

  // circle pairs are strict, circle/box touches count
  always_comb begin
    ux_w  = MW'(ux_i);
    uy_w  = MW'(uy_i);
    lim_w = MW'(lim_i);
    if (ctl_i.mode == MODE_CC) begin
      far_nxt = (ux_w >= lim_w) || (uy_w >= lim_w);
    end else begin
      far_nxt = (ux_w > lim_w) || (uy_w > lim_w);
    end
    // when not far the operands fit the bound's width
    opx = ux_w[SUM_BITS-1:0];
    opy = uy_w[SUM_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_i.valid;
    end
    ctl_r.mode   <= ctl_i.mode;
    ctl_r.bb_hit <= ctl_i.bb_hit;
    ctl_r.far    <= far_nxt;
    sqx_r        <= opx * opx;
    sqy_r        <= opy * opy;
    sqr_r        <= lim_i * lim_i;
  end

  assign ctl_o = ctl_r;
  assign sqx_o = sqx_r;
  assign sqy_o = sqy_r;
  assign sqr_o = sqr_r;

endmodule

`default_nettype wire

@@ rtl/bcot_decide.sv @@
// Last pipeline stage: sum of squares against the squared bound, result word.
// Depends on bcot_pkg.
`default_nettype none

`include "box_circle_overlap_test_defines.svh"

module bcot_decide (
  input  wire                               clk,
  input  wire                               rst_n,
  input  bcot_pkg::stage_ctl_t              ctl_i,
  input  wire  [bcot_pkg::SQ_BITS-1:0]      sqx_i,
  input  wire  [bcot_pkg::SQ_BITS-1:0]      sqy_i,
  input  wire  [bcot_pkg::SQ_BITS-1:0]      sqr_i,
  output logic                              strobe_o,
  output logic                              overlap_o
);
  import bcot_pkg::*;

  logic [SQ_BITS:0] sum_sq, bound_sq;
  logic             hit_nxt;
  logic             strobe_r, overlap_r;

  always_comb begin
    sum_sq   = {1'b0, sqx_i} + {1'b0, sqy_i};
    bound_sq = {1'b0, sqr_i};
    case (ctl_i.mode)
      MODE_BB: hit_nxt = ctl_i.bb_hit;
      MODE_CC: hit_nxt = !ctl_i.far && (sum_sq < bound_sq);
      MODE_CB: hit_nxt = !ctl_i.far && (sum_sq <= bound_sq);
      default: hit_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= ctl_i.valid;
    end
    overlap_r <= hit_nxt;
  end

  assign strobe_o  = strobe_r;
  assign overlap_o = overlap_r;

  // a far pair of round shapes never reports a hit
  `BCOT_ASSERT_NEXT(a_far_miss, ctl_i.valid && ctl_i.far && (ctl_i.mode != MODE_BB),
    strobe_r && !overlap_r, "far pair reported as overlapping")

endmodule

`default_nettype wire
